FILE: rtl/vabp_pkg.sv
package vabp_pkg;

    localparam int unsigned SIG_LEN       = 20;
    localparam int unsigned MIN_FILE_LEN  = 26;
    localparam int unsigned MIN_HDR_OFF   = 22;
    localparam int unsigned T1_MIN_LEN    = 2;
    localparam int unsigned T9_MIN_LEN    = 12;
    localparam int unsigned T9_DATA_START = 12;

    localparam logic [31:0] FILE_LEN_RESET = 32'd26;
    localparam logic [31:0] RESET_RATE     = 32'd11025;

    // rate of a type 1 block: RATE_DIVIDEND / (TC_BASE - tc)
    localparam int unsigned QUO_W = 20;
    localparam int unsigned DVS_W = 9;
    localparam logic [QUO_W-1:0] RATE_DIVIDEND = 20'd1000000;
    localparam logic [DVS_W-1:0] TC_BASE       = 9'd256;

    localparam logic [7:0] TYPE_END       = 8'd0;
    localparam logic [7:0] TYPE_SOUND     = 8'd1;
    localparam logic [7:0] TYPE_SOUND_NEW = 8'd9;
    localparam logic [7:0] CODEC_PCM8     = 8'd0;
    localparam logic [7:0] BITS_8         = 8'd8;
    localparam logic [7:0] CHANNELS_MONO  = 8'd1;

    localparam logic       KIND_SAMPLE = 1'b0;
    localparam logic       KIND_DONE   = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_SHORT    = 2'd1;
    localparam logic [1:0] STATUS_BAD_HDR  = 2'd2;
    localparam logic [1:0] STATUS_NO_AUDIO = 2'd3;

    typedef enum logic [5:0] {
        PH_SIG  = 6'b000001,
        PH_HDR  = 6'b000010,
        PH_SKIP = 6'b000100,
        PH_BHDR = 6'b001000,
        PH_BODY = 6'b010000,
        PH_STOP = 6'b100000
    } phase_t;

    typedef struct packed {
        logic step;
        logic div_start;
        logic load_done;
    } cmd_t;

    typedef struct packed {
        logic sample_hit;
        logic div_hit;
        logic final_hit;
        logic div_done;
        logic out_free;
    } stat_t;

    function automatic logic [7:0] sig_byte(input logic [4:0] idx);
        logic [7:0] r;
        case (idx)
            5'd0:    r = 8'h43;
            5'd1:    r = 8'h72;
            5'd2:    r = 8'h65;
            5'd3:    r = 8'h61;
            5'd4:    r = 8'h74;
            5'd5:    r = 8'h69;
            5'd6:    r = 8'h76;
            5'd7:    r = 8'h65;
            5'd8:    r = 8'h20;
            5'd9:    r = 8'h56;
            5'd10:   r = 8'h6F;
            5'd11:   r = 8'h69;
            5'd12:   r = 8'h63;
            5'd13:   r = 8'h65;
            5'd14:   r = 8'h20;
            5'd15:   r = 8'h46;
            5'd16:   r = 8'h69;
            5'd17:   r = 8'h6C;
            5'd18:   r = 8'h65;
            5'd19:   r = 8'h1A;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/vabp_div.sv
module vabp_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [vabp_pkg::DVS_W-1:0]  divisor,
    output logic                        done,
    output logic [vabp_pkg::QUO_W-1:0]  quotient
);
    import vabp_pkg::*;

    localparam int unsigned CNT_W = $clog2(QUO_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DVS_W-1:0]   rem_reg, rem_next;
    logic [DVS_W-1:0]   dvs_reg, dvs_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [DVS_W:0]     rem_shift;
    logic [DVS_W:0]     rem_sub;

    // one quotient bit per cycle, restoring
    assign rem_shift = {rem_reg, quo_reg[QUO_W-1]};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = RATE_DIVIDEND;
        end
        else if (busy_reg)
        begin
            if (rem_shift >= {1'b0, dvs_reg})
            begin
                rem_next = rem_sub[DVS_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DVS_W-1:0];
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/vabp_dp.sv
module vabp_dp (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    input  logic [31:0]     file_length,
    input  logic [7:0]      data_byte,
    input  vabp_pkg::cmd_t  cmd,
    output vabp_pkg::stat_t stat,
    output logic            out_valid,
    input  logic            out_stall,
    output logic            kind,
    output logic [7:0]      pcm_sample,
    output logic [31:0]     sample_rate,
    output logic [1:0]      status,
    output logic [31:0]     sample_count,
    output logic            last
);
    import vabp_pkg::*;

    logic [31:0] len_reg;
    logic [31:0] pos_reg,     pos_next;
    phase_t      phase_reg,   phase_next;
    logic [15:0] hdr_reg,     hdr_next;
    logic [7:0]  btype_reg,   btype_next;
    logic [23:0] blen_reg,    blen_next;
    logic [23:0] bidx_reg,    bidx_next;
    logic [7:0]  tc_reg,      tc_next;
    logic [31:0] racc_reg,    racc_next;
    logic [31:0] rate_reg,    rate_next;
    logic [31:0] samples_reg, samples_next;
    logic        pen_reg,     pen_next;
    logic [1:0]  err_reg,     err_next;

    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [7:0]  out_pcm_reg;
    logic [31:0] out_rate_reg;
    logic [1:0]  out_status_reg;
    logic [31:0] out_count_reg;

    logic        in_range;
    logic        final_hit;
    logic        sample_hit;
    logic        div_hit;
    logic [15:0] hdr_new;
    logic [23:0] blen_shift;
    logic [23:0] blen_new;
    logic [32:0] end_sum;
    logic [31:0] racc_base;
    logic [31:0] racc_shift;
    logic [31:0] racc_new;
    logic [23:0] bidx_inc;
    logic [1:0]  done_status;
    logic [QUO_W-1:0] quotient;

    assign in_range  = (len_reg != 32'd0) && (pos_reg < len_reg);
    assign final_hit = in_range && (pos_reg == len_reg - 32'd1);

    assign hdr_new  = hdr_reg | {data_byte, 8'h00};
    assign blen_new = blen_reg | blen_shift;
    assign end_sum  = {1'b0, pos_reg} + 33'd1 + {9'd0, blen_new};
    assign racc_new = racc_base | racc_shift;
    assign bidx_inc = bidx_reg + 24'd1;

    always_comb
    begin
        case (bidx_reg[1:0])
            2'd1:    blen_shift = {16'h0000, data_byte};
            2'd2:    blen_shift = {8'h00, data_byte, 8'h00};
            default: blen_shift = {data_byte, 16'h0000};
        endcase
        case (bidx_reg[1:0])
            2'd0:    racc_shift = {24'h000000, data_byte};
            2'd1:    racc_shift = {16'h0000, data_byte, 8'h00};
            2'd2:    racc_shift = {8'h00, data_byte, 16'h0000};
            default: racc_shift = {data_byte, 24'h000000};
        endcase
        racc_base = (bidx_reg[1:0] == 2'd0) ? 32'd0 : racc_reg;
    end

    always_comb
    begin
        pos_next     = pos_reg;
        phase_next   = phase_reg;
        hdr_next     = hdr_reg;
        btype_next   = btype_reg;
        blen_next    = blen_reg;
        bidx_next    = bidx_reg;
        tc_next      = tc_reg;
        racc_next    = racc_reg;
        rate_next    = rate_reg;
        samples_next = samples_reg;
        pen_next     = pen_reg;
        err_next     = err_reg;
        sample_hit   = 1'b0;
        div_hit      = 1'b0;

        if (in_range)
        begin
            pos_next = pos_reg + 32'd1;
            case (phase_reg)
                PH_SIG:
                begin
                    if (len_reg < 32'(MIN_FILE_LEN))
                    begin
                        err_next   = STATUS_SHORT;
                        phase_next = PH_STOP;
                    end
                    else if (pos_reg >= 32'(SIG_LEN) || data_byte != sig_byte(pos_reg[4:0]))
                    begin
                        err_next   = STATUS_BAD_HDR;
                        phase_next = PH_STOP;
                    end
                    else if (pos_reg == 32'(SIG_LEN - 1))
                    begin
                        phase_next = PH_HDR;
                    end
                end
                PH_HDR:
                begin
                    if (pos_reg == 32'(SIG_LEN))
                    begin
                        hdr_next = {8'h00, data_byte};
                    end
                    else
                    begin
                        hdr_next = hdr_new;
                        if (hdr_new < 16'(MIN_HDR_OFF))
                        begin
                            err_next   = STATUS_BAD_HDR;
                            phase_next = PH_STOP;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (pos_reg >= {16'h0000, hdr_reg})
                    begin
                        bidx_next = 24'd0;
                        if (data_byte == TYPE_END)
                        begin
                            phase_next = PH_STOP;
                        end
                        else
                        begin
                            phase_next = PH_BHDR;
                            btype_next = data_byte;
                            blen_next  = 24'd0;
                            bidx_next  = 24'd1;
                        end
                    end
                end
                PH_BHDR:
                begin
                    if (bidx_reg[1:0] == 2'd0)
                    begin
                        if (data_byte == TYPE_END)
                        begin
                            phase_next = PH_STOP;
                        end
                        else
                        begin
                            btype_next = data_byte;
                            blen_next  = 24'd0;
                            bidx_next  = 24'd1;
                        end
                    end
                    else
                    begin
                        blen_next = blen_new;
                        if (bidx_reg[1:0] != 2'd3)
                        begin
                            bidx_next = bidx_inc;
                        end
                        else
                        begin
                            bidx_next = 24'd0;
                            // drop the walk when the block runs past the file
                            if (end_sum > {1'b0, len_reg})
                            begin
                                phase_next = PH_STOP;
                            end
                            else if (blen_new != 24'd0)
                            begin
                                phase_next = PH_BODY;
                                pen_next   = 1'b0;
                            end
                        end
                    end
                end
                PH_BODY:
                begin
                    if (btype_reg == TYPE_SOUND && blen_reg >= 24'(T1_MIN_LEN))
                    begin
                        if (bidx_reg == 24'd0)
                        begin
                            tc_next = data_byte;
                        end
                        else if (bidx_reg == 24'd1)
                        begin
                            if (data_byte == CODEC_PCM8)
                            begin
                                div_hit  = 1'b1;
                                pen_next = 1'b1;
                            end
                        end
                        else if (pen_reg)
                        begin
                            sample_hit = 1'b1;
                        end
                    end
                    else if (btype_reg == TYPE_SOUND_NEW && blen_reg >= 24'(T9_MIN_LEN))
                    begin
                        if (bidx_reg < 24'd4)
                        begin
                            racc_next = racc_new;
                            if (bidx_reg == 24'd3 && racc_new != 32'd0)
                            begin
                                rate_next = racc_new;
                            end
                        end
                        else if (bidx_reg == 24'd4)
                        begin
                            tc_next = data_byte;
                        end
                        else if (bidx_reg == 24'd5)
                        begin
                            pen_next = (tc_reg == BITS_8) && (data_byte == CHANNELS_MONO);
                        end
                        else if (bidx_reg >= 24'(T9_DATA_START) && pen_reg)
                        begin
                            sample_hit = 1'b1;
                        end
                    end
                    bidx_next = bidx_inc;
                    if (bidx_inc == blen_reg)
                    begin
                        phase_next = PH_BHDR;
                        bidx_next  = 24'd0;
                    end
                    if (sample_hit)
                    begin
                        samples_next = samples_reg + 32'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (len_reg < 32'(MIN_FILE_LEN))
        begin
            done_status = STATUS_SHORT;
        end
        else if (err_reg != STATUS_OK)
        begin
            done_status = err_reg;
        end
        else if (samples_reg == 32'd0)
        begin
            done_status = STATUS_NO_AUDIO;
        end
        else
        begin
            done_status = STATUS_OK;
        end
    end

    vabp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .divisor  (TC_BASE - {1'b0, tc_reg}),
        .done     (stat.div_done),
        .quotient (quotient)
    );

    assign stat.sample_hit = sample_hit;
    assign stat.div_hit    = div_hit;
    assign stat.final_hit  = final_hit;
    assign stat.out_free   = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= FILE_LEN_RESET;
            pos_reg     <= '0;
            phase_reg   <= PH_SIG;
            hdr_reg     <= '0;
            btype_reg   <= '0;
            blen_reg    <= '0;
            bidx_reg    <= '0;
            tc_reg      <= '0;
            racc_reg    <= '0;
            rate_reg    <= RESET_RATE;
            samples_reg <= '0;
            pen_reg     <= 1'b0;
            err_reg     <= STATUS_OK;
        end
        else
        begin
            if (cfg_valid)
            begin
                len_reg <= file_length;
            end
            if (cmd.step)
            begin
                pos_reg     <= pos_next;
                phase_reg   <= phase_next;
                hdr_reg     <= hdr_next;
                btype_reg   <= btype_next;
                blen_reg    <= blen_next;
                bidx_reg    <= bidx_next;
                tc_reg      <= tc_next;
                racc_reg    <= racc_next;
                rate_reg    <= rate_next;
                samples_reg <= samples_next;
                pen_reg     <= pen_next;
                err_reg     <= err_next;
            end
            else if (stat.div_done)
            begin
                rate_reg <= {{(32 - QUO_W){1'b0}}, quotient};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((cmd.step && sample_hit) || cmd.load_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step && sample_hit)
        begin
            out_kind_reg   <= KIND_SAMPLE;
            out_pcm_reg    <= data_byte;
            out_rate_reg   <= rate_reg;
            out_status_reg <= STATUS_OK;
            out_count_reg  <= samples_next;
        end
        else if (cmd.load_done)
        begin
            out_kind_reg   <= KIND_DONE;
            out_pcm_reg    <= 8'h00;
            out_rate_reg   <= rate_reg;
            out_status_reg <= done_status;
            out_count_reg  <= samples_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_kind_reg;
    assign pcm_sample   = out_pcm_reg;
    assign sample_rate  = out_rate_reg;
    assign status       = out_status_reg;
    assign sample_count = out_count_reg;
    assign last         = out_kind_reg;

endmodule

FILE: rtl/vabp_ctrl.sv
module vabp_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  vabp_pkg::stat_t stat,
    output vabp_pkg::cmd_t  cmd
);
    import vabp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        pend_reg, pend_next;

    always_comb
    begin
        state_next    = state_reg;
        pend_next     = pend_reg;
        cmd.step      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.load_done = 1'b0;
        in_stall      = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = !stat.out_free;
                if (in_valid && stat.out_free)
                begin
                    cmd.step = 1'b1;
                    if (stat.div_hit)
                    begin
                        // hold input until the new rate is in place
                        cmd.div_start = 1'b1;
                        pend_next     = stat.final_hit;
                        state_next    = ST_DIV;
                    end
                    else if (stat.final_hit)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = pend_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_done = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

FILE: rtl/voc_audio_block_parser_top.sv
// Voice-format audio file parser.
// Input channel: one file byte per item on data_byte (in_valid / in_stall).
// Config channel: file_length written through cfg_valid / cfg_ready; ready is
// always high. Write it only while the parser is idle.
// Output channel: sample items (kind 0) carrying one unsigned 8-bit mono
// sample, and one done item (kind 1, last 1) on the final file byte with
// status, rate and total sample count (out_valid / out_stall).
// Throughput: one byte per cycle while the output register drains. The codec
// byte of a type 1 block, when it names 8-bit PCM, starts the rate divider, a
// one-bit-per-cycle restoring unit that holds input until the new rate is set.
// The done item is loaded from a done state after the final byte's sample item.
// A sample item appears on the output in the cycle after its byte is accepted.
// A stalled output item holds; the next byte is accepted in the same cycle
// the held item leaves, so a stalled receiver stalls the input one for one.
// Reset clears the parse state, sets the rate to 11025 and file_length to 26.
module voc_audio_block_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] file_length,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [7:0]  pcm_sample,
    output logic [31:0] sample_rate,
    output logic [1:0]  status,
    output logic [31:0] sample_count,
    output logic        last
);
    import vabp_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    vabp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    vabp_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .file_length  (file_length),
        .data_byte    (data_byte),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .pcm_sample   (pcm_sample),
        .sample_rate  (sample_rate),
        .status       (status),
        .sample_count (sample_count),
        .last         (last)
    );

    a_div_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> in_stall)
        else $error("input taken while rate divider runs");

    a_div_done_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> in_stall)
        else $error("divider finished outside of rate wait");

    a_step_vs_done: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.step && cmd.load_done))
        else $error("byte step and done load in one cycle");

    a_sample_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_SAMPLE) |-> (status == STATUS_OK && !last))
        else $error("sample item with done fields");

endmodule
